/* src/tsc_pkg.sv */
`default_nettype none
package tsc_pkg;

  // Filter and table constants.
  localparam int unsigned ALPHA_Q16     = 6554;
  localparam int unsigned LUT_ADDR_BITS = 8;
  localparam int unsigned LUT_N         = 1 << LUT_ADDR_BITS;
  localparam int unsigned FSH           = 16 - LUT_ADDR_BITS;
  localparam int unsigned TBL_W         = 18;
  localparam int unsigned IDX_W         = LUT_ADDR_BITS + 1;
  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [13:0] DEAD_SAT      = 14'd13107;
  localparam logic [16:0] ALPHA_C       = 17'(ALPHA_Q16);
  localparam logic [16:0] KEEP_C        = 17'(65536 - ALPHA_Q16);
  localparam logic [63:0] LOG10_OF_2_Q32 = 64'd1292913986;

  localparam logic [2:0] CFG_RAW_MIN   = 3'd0;
  localparam logic [2:0] CFG_RAW_MAX   = 3'd1;
  localparam logic [2:0] CFG_DEAD_LOW  = 3'd2;
  localparam logic [2:0] CFG_DEAD_HIGH = 3'd3;
  localparam logic [2:0] CFG_MODE      = 3'd4;
  localparam logic [2:0] CFG_EXPONENT  = 3'd5;

  localparam logic [1:0] MODE_EXPO = 2'd1;
  localparam logic [1:0] MODE_LOG  = 2'd2;

  localparam int unsigned TBL_LOG10 = 0;
  localparam int unsigned TBL_LOG2  = 1;
  localparam int unsigned TBL_EXP2  = 2;

  typedef logic [TBL_W-1:0] tbl_t [0:LUT_N];

  typedef enum logic [1:0] {
    LK_LOG10,
    LK_LOG2,
    LK_EXP2
  } lk_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILT1,
    S_FILT2,
    S_PREP,
    S_DIV,
    S_DZ,
    S_SHAPE,
    S_NORM,
    S_LOG2,
    S_PMUL,
    S_EXP,
    S_OUT
  } state_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Input is Q30 and at least one; result is log2 in Q24.
  function automatic logic [31:0] log2_q24(input logic [63:0] y_in);
    logic [63:0] y;
    logic [31:0] e;
    logic [31:0] r;
    y = y_in;
    e = 32'd0;
    r = 32'd0;
    while (y >= (64'd1 << 31)) begin
      y = y >> 1;
      e = e + 32'd1;
    end
    for (int k = 1; k <= 24; k++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        r = r | (32'd1 << (24 - k));
      end
    end
    return (e << 24) | r;
  endfunction

  function automatic tbl_t build_tbl(input int unsigned which);
    tbl_t        t;
    logic [63:0] root [0:LUT_ADDR_BITS];
    logic [63:0] y;
    logic [63:0] p;
    logic [63:0] v;
    root[0] = 64'd2 << 30;
    for (int k = 1; k <= LUT_ADDR_BITS; k++) root[k] = isqrt64(root[k-1] << 30);
    for (int i = 0; i <= LUT_N; i++) begin
      if (which == TBL_LOG10) begin
        y = 64'(LUT_N + 9 * i) << (30 - LUT_ADDR_BITS);
        p = 64'(log2_q24(y)) * LOG10_OF_2_Q32;
        t[i] = TBL_W'((p + (64'd1 << 39)) >> 40);
      end else if (which == TBL_LOG2) begin
        y = 64'(LUT_N + i) << (30 - LUT_ADDR_BITS);
        t[i] = TBL_W'((64'(log2_q24(y)) + 64'd128) >> 8);
      end else begin
        v = 64'd1 << 30;
        for (int k = 1; k <= LUT_ADDR_BITS; k++)
          if (((i >> (LUT_ADDR_BITS - k)) & 1) != 0) v = (v * root[k]) >> 30;
        t[i] = TBL_W'((v + 64'd8192) >> 14);
      end
    end
    if (which == TBL_LOG10) t[LUT_N] = TBL_W'(65536);
    if (which == TBL_EXP2) t[LUT_N] = TBL_W'(131072);
    return t;
  endfunction

  localparam tbl_t LOG10_TBL = build_tbl(TBL_LOG10);
  localparam tbl_t LOG2_TBL  = build_tbl(TBL_LOG2);
  localparam tbl_t EXP2_TBL  = build_tbl(TBL_EXP2);

endpackage
`default_nettype wire

/* src/throttle_sensor_conditioner.sv */
// Throttle sensor conditioner.
// The input channel (in_valid, in_ready, in_sensor_sample) takes one 10-bit
// Hall sensor word. The block filters it into a running average, maps it
// between raw_min and raw_max, applies the deadzones and the selected curve,
// and offers one Q1.16 throttle word on the result channel (out_valid,
// out_ready, out_throttle_level).
// Each word passes through the 26-step restoring divider and, in exponential
// mode, also the one-bit-a-cycle normalizing shift, all run by one sequencer
// that also shares a single table interpolation unit.
// in_ready is high only while the sequencer is idle, so a new word is taken
// only after the sequencer has passed on the previous result.
// The result sits in an output register, so a new word may be accepted while
// the previous result waits. If the receiver stalls, the sequencer holds the
// finished result until the output register frees up.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata), to be
// used while the block is idle. Reset restores the default calibration and
// clears the filter state and the output valid flag.
`default_nettype none
module throttle_sensor_conditioner
  import tsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [9:0]  in_sensor_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [16:0]      out_throttle_level,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  state_t       state_r, state_nxt;
  logic [9:0]   raw_min_r, raw_max_r;
  logic [13:0]  dead_low_r, dead_high_r;
  logic [1:0]   mode_r;
  logic [15:0]  exp_r;
  logic [25:0]  f_r, f_nxt;
  logic [9:0]   samp_r, samp_nxt;
  logic [42:0]  prod_r, prod_nxt;
  logic [25:0]  quo_r, quo_nxt;
  logic [9:0]   rem_r, rem_nxt;
  logic [4:0]   cnt_r, cnt_nxt;
  logic [16:0]  x_r, x_nxt;
  logic [16:0]  m_r, m_nxt;
  logic [4:0]   s_r, s_nxt;
  logic [20:0]  l_r, l_nxt;
  logic [24:0]  n_r, n_nxt;
  logic [16:0]  res_r, res_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [16:0]  out_level_r, out_level_nxt;

  // Shared table interpolation unit.
  lk_sel_t          lk_sel;
  logic [16:0]      lk_a;
  logic [IDX_W-1:0] lk_i0, lk_i1;
  logic [TBL_W-1:0] lk_t0, lk_t1, lk_out;
  logic [TBL_W+FSH-1:0] lk_prod;

  always_comb begin
    lk_i0 = lk_a[16] ? IDX_W'(LUT_N) : lk_a[16:FSH];
    lk_i1 = lk_a[16] ? IDX_W'(LUT_N) : lk_a[16:FSH] + IDX_W'(1);
    case (lk_sel)
      LK_LOG10: begin
        lk_t0 = LOG10_TBL[lk_i0];
        lk_t1 = LOG10_TBL[lk_i1];
      end
      LK_LOG2: begin
        lk_t0 = LOG2_TBL[lk_i0];
        lk_t1 = LOG2_TBL[lk_i1];
      end
      default: begin
        lk_t0 = EXP2_TBL[lk_i0];
        lk_t1 = EXP2_TBL[lk_i1];
      end
    endcase
    lk_prod = (TBL_W+FSH)'(lk_t1 - lk_t0) * (TBL_W+FSH)'(lk_a[FSH-1:0]);
    lk_out  = lk_t0 + lk_prod[TBL_W+FSH-1:FSH];
  end

  logic [9:0]  den;
  logic [43:0] acc;
  logic [26:0] alpha_s;
  logic [25:0] base;
  logic [10:0] trial;
  logic        ge;
  logic [16:0] n_clamp;
  logic [13:0] dl, dh;
  logic [36:0] pw_prod;
  logic [8:0]  q_raw;
  logic [5:0]  q;
  logic [6:0]  sh;
  logic [16:0] lf;

  always_comb begin
    state_nxt     = state_r;
    f_nxt         = f_r;
    samp_nxt      = samp_r;
    prod_nxt      = prod_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    m_nxt         = m_r;
    s_nxt         = s_r;
    l_nxt         = l_r;
    n_nxt         = n_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_level_nxt = out_level_r;
    in_ready      = 1'b0;
    lk_sel        = LK_LOG10;
    lk_a          = x_r;

    den     = (raw_max_r > raw_min_r) ? (raw_max_r - raw_min_r) : 10'd1;
    alpha_s = ALPHA_C * 27'(samp_r);
    acc     = 44'(prod_r) + {1'b0, alpha_s, 16'd0} + 44'd32768;
    base    = {raw_min_r, 16'd0};
    trial   = {rem_r, quo_r[25]};
    ge      = trial >= {1'b0, den};
    n_clamp = (quo_r > 26'(ONE_Q16)) ? ONE_Q16 : quo_r[16:0];
    dl      = (dead_low_r > DEAD_SAT) ? DEAD_SAT : dead_low_r;
    dh      = (dead_high_r > DEAD_SAT) ? DEAD_SAT : dead_high_r;
    pw_prod = 37'(l_r) * 37'(exp_r) + 37'd2048;
    q_raw   = n_r[24:16];
    q       = (q_raw > 9'd40) ? 6'd40 : q_raw[5:0];
    sh      = 7'(q) + 7'd1;
    lf      = 17'd0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          samp_nxt  = in_sensor_sample;
          state_nxt = S_FILT1;
        end
      end
      S_FILT1: begin
        prod_nxt  = 43'(f_r) * 43'(KEEP_C);
        state_nxt = S_FILT2;
      end
      S_FILT2: begin
        f_nxt     = acc[41:16];
        state_nxt = S_PREP;
      end
      S_PREP: begin
        quo_nxt   = (f_r > base) ? (f_r - base) : 26'd0;
        rem_nxt   = 10'd0;
        cnt_nxt   = 5'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_nxt = ge ? 10'(trial - {1'b0, den}) : trial[9:0];
        quo_nxt = {quo_r[24:0], ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd25) state_nxt = S_DZ;
      end
      S_DZ: begin
        x_nxt = n_clamp;
        if (n_clamp < {3'd0, dl}) x_nxt = 17'd0;
        if (n_clamp > ONE_Q16 - {3'd0, dh}) x_nxt = ONE_Q16;
        state_nxt = S_SHAPE;
      end
      S_SHAPE: begin
        case (mode_r)
          MODE_EXPO: begin
            if (exp_r == 16'd0) begin
              res_nxt   = ONE_Q16;
              state_nxt = S_OUT;
            end else if (x_r == 17'd0) begin
              res_nxt   = 17'd0;
              state_nxt = S_OUT;
            end else begin
              m_nxt     = x_r;
              s_nxt     = 5'd0;
              state_nxt = S_NORM;
            end
          end
          MODE_LOG: begin
            lk_sel    = LK_LOG10;
            lk_a      = x_r;
            res_nxt   = lk_out[16:0];
            state_nxt = S_OUT;
          end
          default: begin
            res_nxt   = x_r;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_NORM: begin
        if (m_r[16]) begin
          state_nxt = S_LOG2;
        end else begin
          m_nxt = {m_r[15:0], 1'b0};
          s_nxt = s_r + 5'd1;
        end
      end
      S_LOG2: begin
        lk_sel    = LK_LOG2;
        lk_a      = {1'b0, m_r[15:0]};
        lf        = (s_r == 5'd0) ? 17'd0 : lk_out[16:0];
        l_nxt     = {s_r, 16'd0} - 21'(lf);
        state_nxt = S_PMUL;
      end
      S_PMUL: begin
        n_nxt     = pw_prod[36:12];
        state_nxt = S_EXP;
      end
      S_EXP: begin
        lk_sel = LK_EXP2;
        lk_a   = ONE_Q16 - {1'b0, n_r[15:0]};
        if (n_r[15:0] == 16'd0) begin
          res_nxt = (q > 6'd16) ? 17'd0 : (ONE_Q16 >> q);
        end else begin
          res_nxt = (sh > 7'd20) ? 17'd0 : 17'(lk_out >> sh);
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = (res_r > ONE_Q16) ? ONE_Q16 : res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      f_r         <= 26'd0;
      out_valid_r <= 1'b0;
      raw_min_r   <= 10'd200;
      raw_max_r   <= 10'd900;
      dead_low_r  <= 14'd0;
      dead_high_r <= 14'd0;
      mode_r      <= 2'd0;
      exp_r       <= 16'd6554;
    end else begin
      state_r     <= state_nxt;
      f_r         <= f_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RAW_MIN:   raw_min_r   <= cfg_wdata[9:0];
          CFG_RAW_MAX:   raw_max_r   <= cfg_wdata[9:0];
          CFG_DEAD_LOW:  dead_low_r  <= cfg_wdata[13:0];
          CFG_DEAD_HIGH: dead_high_r <= cfg_wdata[13:0];
          CFG_MODE:      mode_r      <= cfg_wdata[1:0];
          CFG_EXPONENT:  exp_r       <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    samp_r      <= samp_nxt;
    prod_r      <= prod_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    x_r         <= x_nxt;
    m_r         <= m_nxt;
    s_r         <= s_nxt;
    l_r         <= l_nxt;
    n_r         <= n_nxt;
    res_r       <= res_nxt;
    out_level_r <= out_level_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_throttle_level = out_level_r;

  a_accept_starts_filter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_FILT1))
    else $error("accepted word did not start the filter step");

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_throttle_level <= ONE_Q16))
    else $error("throttle level above full scale");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < den))
    else $error("divider remainder not below divisor");

  a_out_held_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ready) |=> (state_r == S_OUT))
    else $error("result left the sequencer while output register was full");

endmodule
`default_nettype wire

/* tb/tb_throttle_sensor_conditioner.sv */
`default_nettype none
module tb_throttle_sensor_conditioner;
  import tsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_WORDS = 1750;
  localparam logic [1:0]  MODE_LINEAR  = 2'd0;
  localparam logic [1:0]  MODE_ALT_LIN = 2'd3;
  localparam int unsigned NPTS         = 1 << LUT_ADDR_BITS;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [9:0]  in_sensor_sample;
  logic        out_valid;
  logic        out_ready;
  logic [16:0] out_throttle_level;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  throttle_sensor_conditioner dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sensor_sample(in_sensor_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_throttle_level(out_throttle_level),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the calibration and filter state.
  logic [9:0]  cal_min, cal_max;
  logic [13:0] dz_low, dz_high;
  logic [1:0]  shape_mode;
  logic [15:0] shape_expo;
  logic [25:0] avg_reading;

  logic [63:0] log10_pts [0:NPTS];
  logic [63:0] log2_pts  [0:NPTS];
  logic [63:0] exp2_pts  [0:NPTS];

  logic [16:0] level_q [$];
  int unsigned errors;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] int_root(input logic [63:0] val);
    logic [63:0] rem, res, bitv;
    rem = val;
    res = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] binlog_q24(input logic [63:0] arg);
    logic [63:0] y, ipart, frac;
    y = arg;
    ipart = 0;
    frac = 0;
    while (y >= (64'd1 << 31)) begin
      y = y >> 1;
      ipart++;
    end
    for (int k = 1; k <= 24; k++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        frac = frac | (64'd1 << (24 - k));
      end
    end
    return (ipart << 24) | frac;
  endfunction

  task automatic fill_curves();
    logic [63:0] roots [0:LUT_ADDR_BITS];
    logic [63:0] y, acc;
    roots[0] = 64'd2 << 30;
    for (int k = 1; k <= LUT_ADDR_BITS; k++) roots[k] = int_root(roots[k-1] << 30);
    for (int i = 0; i <= NPTS; i++) begin
      y = 64'(NPTS + 9 * i) << (30 - LUT_ADDR_BITS);
      log10_pts[i] = (binlog_q24(y) * LOG10_OF_2_Q32 + (64'd1 << 39)) >> 40;
      y = 64'(NPTS + i) << (30 - LUT_ADDR_BITS);
      log2_pts[i] = (binlog_q24(y) + 64'd128) >> 8;
      acc = 64'd1 << 30;
      for (int k = 1; k <= LUT_ADDR_BITS; k++)
        if (((i >> (LUT_ADDR_BITS - k)) & 1) != 0) acc = (acc * roots[k]) >> 30;
      exp2_pts[i] = (acc + 64'd8192) >> 14;
    end
    log10_pts[NPTS] = 64'd65536;
    exp2_pts[NPTS] = 64'd131072;
  endtask

  function automatic logic [63:0] interp(input lk_sel_t sel, input logic [63:0] a);
    logic [63:0] idx, lo, hi;
    idx = a >> FSH;
    if (idx >= NPTS) idx = NPTS;
    case (sel)
      LK_LOG10: begin lo = log10_pts[idx]; hi = (idx < NPTS) ? log10_pts[idx+1] : lo; end
      LK_LOG2:  begin lo = log2_pts[idx];  hi = (idx < NPTS) ? log2_pts[idx+1]  : lo; end
      default:  begin lo = exp2_pts[idx];  hi = (idx < NPTS) ? exp2_pts[idx+1]  : lo; end
    endcase
    if (idx >= NPTS) return lo;
    return lo + (((hi - lo) * (a & ((64'd1 << FSH) - 1))) >> FSH);
  endfunction

  function automatic logic [63:0] raise_power(input logic [63:0] x);
    logic [63:0] m, s, lf, l, n, q, r, v;
    if (shape_expo == 0) return 64'd65536;
    if (x == 0) return 64'd0;
    m = x;
    s = 0;
    while (m < 64'd65536) begin
      m = m << 1;
      s++;
    end
    lf = (s == 0) ? 64'd0 : interp(LK_LOG2, m - 64'd65536);
    l = s * 64'd65536 - lf;
    n = (l * shape_expo + 64'd2048) >> 12;
    q = ((n >> 16) > 40) ? 64'd40 : (n >> 16);
    r = n & 64'hFFFF;
    if (r == 0) return (q > 16) ? 64'd0 : (64'd65536 >> q);
    v = interp(LK_EXP2, 64'd65536 - r);
    return (q + 1 > 20) ? 64'd0 : (v >> (q + 1));
  endfunction

  // Advances the filter and returns the throttle word for one sample.
  function automatic logic [16:0] condition_sample(input logic [9:0] sample);
    logic [63:0] acc, base, den, n, dl, dh, y;
    acc = 64'(avg_reading) * (64'd65536 - ALPHA_Q16)
        + 64'(ALPHA_Q16) * (64'(sample) << 16) + 64'd32768;
    avg_reading = 26'(acc >> 16);
    base = 64'(cal_min) << 16;
    den = (cal_max > cal_min) ? 64'(cal_max - cal_min) : 64'd1;
    n = (64'(avg_reading) > base) ? (64'(avg_reading) - base) / den : 64'd0;
    if (n > 64'd65536) n = 64'd65536;
    dl = (dz_low > DEAD_SAT) ? 64'(DEAD_SAT) : 64'(dz_low);
    dh = (dz_high > DEAD_SAT) ? 64'(DEAD_SAT) : 64'(dz_high);
    if (n < dl) n = 0;
    if (n > 64'd65536 - dh) n = 64'd65536;
    if (shape_mode == MODE_EXPO) y = raise_power(n);
    else if (shape_mode == MODE_LOG) y = interp(LK_LOG10, n);
    else y = n;
    if (y > 64'd65536) y = 64'd65536;
    return y[16:0];
  endfunction

  task automatic report(input string what, input logic [16:0] got, input logic [16:0] want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Result checker and run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", level_q.size());
      $display("FAILED: results differ");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (level_q.size() == 0) begin
        report("unexpected word", out_throttle_level, 17'd0);
      end else begin
        if (out_throttle_level !== level_q[0])
          report("throttle_level", out_throttle_level, level_q[0]);
        void'(level_q.pop_front());
      end
    end
  end

  // Receiver: stalls in runs, with calm stretches of full readiness.
  int unsigned stall_pct;
  int unsigned run_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      run_left <= 0;
      stall_pct <= 0;
    end else begin
      if (run_left == 0) begin
        run_left <= $urandom_range(200, 10);
        case ($urandom_range(3))
          0: stall_pct <= 0;
          1: stall_pct <= 20;
          2: stall_pct <= 60;
          default: stall_pct <= 90;
        endcase
      end else begin
        run_left <= run_left - 1;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(input logic [9:0] sample, input logic chk, input logic [16:0] want);
    logic [16:0] pred;
    in_valid <= 1'b1;
    in_sensor_sample <= sample;
    do @(posedge clk); while (!in_ready);
    pred = condition_sample(sample);
    if (chk && pred !== want) report("directed table", pred, want);
    level_q.push_back(chk ? want : pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RAW_MIN:   cal_min = val[9:0];
      CFG_RAW_MAX:   cal_max = val[9:0];
      CFG_DEAD_LOW:  dz_low = val[13:0];
      CFG_DEAD_HIGH: dz_high = val[13:0];
      CFG_MODE:      shape_mode = val[1:0];
      CFG_EXPONENT:  shape_expo = val;
      default: ;
    endcase
  endtask

  typedef struct {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [15:0] val;
    logic        chk;
    logic [16:0] want;
  } step_t;

  step_t plan [] = '{
    '{1'b0, 3'd0, 16'd0,     1'b1, 17'd0},      // filter starts at zero
    '{1'b0, 3'd0, 16'd1023,  1'b0, 17'd0},
    '{1'b0, 3'd0, 16'd1023,  1'b0, 17'd0},
    '{1'b1, CFG_MODE, 16'(MODE_EXPO), 1'b0, 17'd0},
    '{1'b0, 3'd0, 16'd1023,  1'b0, 17'd0},
    '{1'b1, CFG_EXPONENT, 16'd0, 1'b0, 17'd0},
    '{1'b0, 3'd0, 16'd0,     1'b1, 17'd65536},  // zero exponent is always full
    '{1'b1, CFG_EXPONENT, 16'hFFFF, 1'b0, 17'd0},
    '{1'b0, 3'd0, 16'd700,   1'b0, 17'd0},
    '{1'b1, CFG_MODE, 16'(MODE_LOG), 1'b0, 17'd0},
    '{1'b0, 3'd0, 16'd600,   1'b0, 17'd0},
    '{1'b1, CFG_MODE, 16'(MODE_ALT_LIN), 1'b0, 17'd0},
    '{1'b0, 3'd0, 16'd500,   1'b0, 17'd0},
    '{1'b1, CFG_DEAD_LOW, 16'h3FFF, 1'b0, 17'd0},
    '{1'b1, CFG_DEAD_HIGH, 16'h3FFF, 1'b0, 17'd0},
    '{1'b0, 3'd0, 16'd300,   1'b0, 17'd0},
    '{1'b0, 3'd0, 16'd1000,  1'b0, 17'd0},
    '{1'b1, CFG_RAW_MIN, 16'd1023, 1'b0, 17'd0},
    '{1'b1, CFG_RAW_MAX, 16'd0, 1'b0, 17'd0},    // inverted calibration
    '{1'b0, 3'd0, 16'd1023,  1'b0, 17'd0},
    '{1'b1, CFG_RAW_MAX, 16'd1023, 1'b0, 17'd0},
    '{1'b0, 3'd0, 16'd0,     1'b0, 17'd0}
  };

  initial begin
    int unsigned gap, left, target, cur;
    logic [9:0]  smp;
    in_valid = 1'b0;
    in_sensor_sample = 10'd0;
    cfg_we = 1'b0;
    cfg_index = 3'd0;
    cfg_wdata = 16'd0;
    out_ready = 1'b0;
    errors = 0;
    cycles = 0;
    cal_min = 10'd200; cal_max = 10'd900; dz_low = 0; dz_high = 0;
    shape_mode = MODE_LINEAR; shape_expo = 16'd6554; avg_reading = 0;
    fill_curves();
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
      else send_word(plan[i].val[9:0], plan[i].chk, plan[i].want);
    end

    left = RANDOM_WORDS;
    cur = 500;
    for (int ph = 0; left > 0; ph++) begin
      // Calibration for this phase; the first two phases use the extremes.
      write_reg(CFG_RAW_MIN, ph == 0 ? 16'd0 : 16'($urandom_range(1023)));
      write_reg(CFG_RAW_MAX, ph == 0 ? 16'd1023 :
                ($urandom_range(5) == 0 ? 16'($urandom_range(1023)) :
                 16'(cal_min + $urandom_range(1023 - cal_min))));
      write_reg(CFG_DEAD_LOW, ph == 1 ? 16'h3FFF : 16'($urandom_range(16383)));
      write_reg(CFG_DEAD_HIGH, ph == 1 ? 16'h3FFF : 16'($urandom_range(16383)));
      write_reg(CFG_MODE, 16'(ph % 4));
      case ($urandom_range(3))
        0: write_reg(CFG_EXPONENT, 16'($urandom_range(65535)));
        1: write_reg(CFG_EXPONENT, 16'($urandom_range(16384)));
        2: write_reg(CFG_EXPONENT, 16'($urandom_range(4) * 4096));
        default: write_reg(CFG_EXPONENT, ph == 3 ? 16'hFFFF : 16'd0);
      endcase
      target = 150;
      while (target > 0 && left > 0) begin
        // Mostly a random level inside the calibrated span, some raw noise.
        if ($urandom_range(9) < 7) begin
          cur = (cal_max > cal_min) ? $urandom_range(cal_max, cal_min) : $urandom_range(1023);
          smp = 10'(cur);
        end else begin
          smp = 10'($urandom_range(1023));
        end
        for (int b = $urandom_range(8, 1); b > 0 && target > 0 && left > 0; b--) begin
          send_word(smp, 1'b0, 17'd0);
          target--;
          left--;
        end
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    drain();
    if (errors == 0 && level_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
